/* rtl/core/restoring_integer_divider_macros.svh */
// Assertion macros for the restoring integer divider checker.
// Each macro expands to one labeled concurrent assertion clocked on clk with rst_n.
`ifndef RESTORING_INTEGER_DIVIDER_MACROS_SVH
`define RESTORING_INTEGER_DIVIDER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked after the delay dly from the antecedent.
`define RID_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

/* rtl/core/rid_pkg.sv */
// Shared constants and types for the restoring integer divider.
// Used by the bit cell, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rid_pkg;

  // Operand width used for the arithmetic, and the fixed width of each port field.
  localparam int WIDTH  = 64;
  localparam int DATA_W = 64;
  localparam int CNT_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_RUN  = 4'b0100,
    S_FIX  = 4'b1000
  } rid_state_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic load;  // load magnitudes, clear the partial remainder
    logic step;  // perform one shift-subtract iteration
    logic ok;    // trial subtraction succeeded in this iteration
  } rid_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/rid_cell.sv */
// One bit slice of the divider row: partial remainder, quotient and divisor bits.
// Depends on rid_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module rid_cell
  import rid_pkg::*;
(
  input  wire logic      clk,
  input  wire rid_ctrl_t ctrl,
  input  wire logic      ld_quo,
  input  wire logic      ld_div,
  input  wire logic      rem_in,
  input  wire logic      quo_in,
  input  wire logic      borrow_in,
  output logic           rem_o,
  output logic           quo_o,
  output logic           div_o,
  output logic           borrow_o
);

  logic rem_r;
  logic quo_r;
  logic div_r;
  logic diff;

  // Bit of the trial subtraction of the divisor from the shifted remainder.
  assign diff     = rem_in ^ div_r ^ borrow_in;
  assign borrow_o = (~rem_in & div_r) | (~(rem_in ^ div_r) & borrow_in);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= 1'b0;
      quo_r <= ld_quo;
      div_r <= ld_div;
    end else if (ctrl.step) begin
      rem_r <= ctrl.ok ? diff : rem_in;
      quo_r <= quo_in;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign div_o = div_r;

endmodule

`default_nettype wire

/* rtl/core/restoring_integer_divider.sv */
// Top level of the restoring integer divider: sequencer, sign handling, row of cells.
// Depends on rid_pkg and rid_cell.
//
// Usage: one operand word enters on the in_ channel (tdata holds dividend and
// divisor, tuser holds the signed-mode flag) and one result word leaves on the
// out_ channel (tdata holds quotient and remainder, tuser the divide-by-zero flag).
// The block works on one word at a time. After a word is accepted, a load step
// forms the operand magnitudes and loads the row of bit cells, the iteration
// steps each shift one quotient bit into the row (the ripple borrow through the
// row sets the cycle), and a final step applies the sign rules and writes the
// output register. in_tready rises in the same cycle as out_tvalid, so a new word
// is taken only once the previous result has been written to the output register.
// A zero divisor is flagged and gives an all-ones quotient with the dividend as
// remainder, with the same latency. A synchronous active-low reset returns the
// sequencer to idle and drops out_tvalid; the row itself holds no control state.
// If the receiver stalls, the result holds in the output register while the next
// word is accepted and divided; that word then waits in its final step until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none

module restoring_integer_divider
  import rid_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [2*DATA_W-1:0] in_tdata,   // dividend, divisor
  input  wire logic [0:0]          in_tuser,   // is_signed
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [2*DATA_W-1:0]      out_tdata,  // quotient, remainder
  output logic [0:0]               out_tuser   // divide_by_zero
);

  rid_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Operands as received; only the low WIDTH bits of each field take part.
  logic             sgn_r;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] b_r;
  logic             neg_a_r;
  logic             neg_b_r;
  logic             dz_r;

  logic             out_valid_r;
  logic [WIDTH-1:0] out_q_r;
  logic [WIDTH-1:0] out_rem_r;
  logic             out_dz_r;

  logic             in_acc;
  logic             out_free;
  logic             fix_done;

  logic             neg_a;
  logic             neg_b;
  logic [WIDTH-1:0] ua;
  logic [WIDTH-1:0] ub;

  rid_ctrl_t        ctrl;
  logic [WIDTH-1:0] rem_v;
  logic [WIDTH-1:0] quo_v;
  logic [WIDTH-1:0] div_v;
  logic [WIDTH-1:0] borrow_v;
  logic [WIDTH-1:0] rem_in_v;
  logic [WIDTH-1:0] quo_in_v;
  logic [WIDTH-1:0] borrow_in_v;

  logic [WIDTH-1:0] q_fix;
  logic [WIDTH-1:0] r_fix;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign fix_done  = (state_r == S_FIX) && out_free;

  // Magnitudes of the operands, formed in the load cycle.
  assign neg_a = sgn_r && a_r[WIDTH-1];
  assign neg_b = sgn_r && b_r[WIDTH-1];
  assign ua    = neg_a ? (~a_r + WIDTH'(1)) : a_r;
  assign ub    = neg_b ? (~b_r + WIDTH'(1)) : b_r;

  // The trial subtraction succeeds when the bit shifted out of the top was set
  // or when no borrow leaves the top cell.
  assign ctrl.load = (state_r == S_PREP);
  assign ctrl.step = (state_r == S_RUN);
  assign ctrl.ok   = rem_v[WIDTH-1] || !borrow_v[WIDTH-1];

  // Neighbor wiring: the remainder shifts up with the top dividend bit entering
  // at the bottom, and each new quotient bit enters the bottom of the quotient.
  assign rem_in_v    = {rem_v[WIDTH-2:0], quo_v[WIDTH-1]};
  assign quo_in_v    = {quo_v[WIDTH-2:0], ctrl.ok};
  assign borrow_in_v = {borrow_v[WIDTH-2:0], 1'b0};

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    rid_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ld_quo    (ua[i]),
      .ld_div    (ub[i]),
      .rem_in    (rem_in_v[i]),
      .quo_in    (quo_in_v[i]),
      .borrow_in (borrow_in_v[i]),
      .rem_o     (rem_v[i]),
      .quo_o     (quo_v[i]),
      .div_o     (div_v[i]),
      .borrow_o  (borrow_v[i])
    );
  end

  // Sign rules on the unsigned quotient and remainder left in the row.
  always_comb begin
    q_fix = quo_v;
    r_fix = rem_v;
    priority if (dz_r) begin
      q_fix = '1;
      r_fix = a_r;
    end else if (neg_a_r && neg_b_r) begin
      r_fix = ~rem_v + WIDTH'(1);
    end else if (neg_b_r) begin
      q_fix = ~quo_v + WIDTH'(1);
    end else if (neg_a_r) begin
      if (rem_v != '0) begin
        // -(q + 1) is the bitwise inverse of q.
        q_fix = ~quo_v;
        r_fix = div_v - rem_v;
      end else begin
        q_fix = ~quo_v + WIDTH'(1);
      end
    end else begin
      q_fix = quo_v;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // A zero divisor runs the full iteration too, like every other word; its row
        // result is replaced in the fix step.
        cnt_nxt   = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fix_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sgn_r <= in_tuser[0];
      a_r   <= in_tdata[WIDTH-1:0];
      b_r   <= in_tdata[DATA_W+WIDTH-1:DATA_W];
    end
    if (state_r == S_PREP) begin
      neg_a_r <= neg_a;
      neg_b_r <= neg_b;
      dz_r    <= (b_r == '0);
    end
    if (fix_done) begin
      out_q_r   <= q_fix;
      out_rem_r <= r_fix;
      out_dz_r  <= dz_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {DATA_W'(out_rem_r), DATA_W'(out_q_r)};
  assign out_tuser  = out_dz_r;

endmodule

`default_nettype wire

/* rtl/core/rid_checker.sv */
// Port-level checker for the restoring integer divider, bound to the top level.
// Depends on rid_pkg and restoring_integer_divider_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "restoring_integer_divider_macros.svh"

module rid_checker
  import rid_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_tvalid,
  input wire logic                in_tready,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [2*DATA_W-1:0] out_tdata,  // quotient, remainder
  input wire logic [0:0]          out_tuser   // divide_by_zero
);

  logic                in_acc;
  logic                out_stall;
  logic                dz_out;
  logic [2*DATA_W:0]   out_word;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign dz_out    = out_tvalid && out_tuser[0];
  assign out_word  = {out_tuser, out_tdata};

  // A stalled result word holds its value.
  `RID_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stalled result changed")

  // Only one word is in the divider at a time.
  `RID_ASSERT_NEXT(a_one_word, in_acc, !in_tready, "input ready right after acceptance")

  // The input is still closed when the word reaches its sign-fix step.
  `RID_ASSERT_DLY(a_busy_len, in_acc, WIDTH + 2, !in_tready, "input reopened too early")

  // A flagged divide by zero carries an all-ones quotient.
  `RID_ASSERT_SAME(a_dz_quot, dz_out, &out_tdata[WIDTH-1:0], "zero-divisor quotient not all ones")

endmodule

bind restoring_integer_divider rid_checker u_rid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* dv/tb_restoring_integer_divider.sv */
// Self-checking testbench for restoring_integer_divider: corner and random operand words,
// predicted results compared against every output word. Depends on rid_pkg and the RTL.
`timescale 1ns / 1ps

module tb_restoring_integer_divider;
  import rid_pkg::*;

  // The signed-mode flag carried on in_tuser selects the kind of division.
  typedef enum logic {
    OP_UNSIGNED = 1'b0,
    OP_SIGNED   = 1'b1
  } div_mode_t;

  // One result word as the divider should deliver it.
  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              div_by_zero;
  } div_result_t;

  localparam logic [DATA_W-1:0] ONE        = DATA_W'(1);
  localparam logic [DATA_W-1:0] FIELD_MASK = {DATA_W{1'b1}} >> (DATA_W - WIDTH);
  localparam logic [DATA_W-1:0] MOST_NEG   = ONE << (WIDTH - 1);
  localparam logic [DATA_W-1:0] MOST_POS   = FIELD_MASK >> 1;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [2*DATA_W-1:0] in_tdata   = '0;  // dividend, divisor
  logic [0:0]          in_tuser   = '0;  // is_signed
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [2*DATA_W-1:0] out_tdata;        // quotient, remainder
  logic [0:0]          out_tuser;        // divide_by_zero

  // Results predicted for accepted operand words, oldest first.
  div_result_t pending_results[$];
  div_result_t want_word;
  div_result_t got_word;
  int unsigned mismatch_count = 0;
  bit          gaps_enabled   = 1'b1;
  bit          stalls_enabled = 1'b1;

  restoring_integer_divider DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Two's complement negation within the operand width.
  function automatic logic [DATA_W-1:0] twos_neg(input logic [DATA_W-1:0] v);
    return (~v + ONE) & FIELD_MASK;
  endfunction

  // Predicts the quotient, remainder and flag for one operand word. Signed division
  // works on magnitudes; the sign rules below are the block's own, which differ from
  // truncating division when only the dividend is negative.
  function automatic div_result_t divide_words(input div_mode_t mode,
                                               input logic [DATA_W-1:0] dividend,
                                               input logic [DATA_W-1:0] divisor);
    logic [DATA_W-1:0] a, b, mag_a, mag_b, q, r;
    logic              neg_a, neg_b;
    div_result_t       res;
    a = dividend & FIELD_MASK;
    b = divisor & FIELD_MASK;
    mag_a = a;
    mag_b = b;
    neg_a = 1'b0;
    neg_b = 1'b0;
    res.div_by_zero = 1'b0;
    if (b == '0) begin
      res.quotient    = FIELD_MASK;
      res.remainder   = a;
      res.div_by_zero = 1'b1;
      return res;
    end
    if (mode == OP_SIGNED) begin
      neg_a = a[WIDTH-1];
      neg_b = b[WIDTH-1];
      if (neg_a) mag_a = twos_neg(a);
      if (neg_b) mag_b = twos_neg(b);
    end
    q = (mag_a / mag_b) & FIELD_MASK;
    r = (mag_a % mag_b) & FIELD_MASK;
    if (neg_a && neg_b) begin
      r = twos_neg(r);
    end else if (neg_b) begin
      q = twos_neg(q);
    end else if (neg_a) begin
      if (r != '0) begin
        q = twos_neg((q + ONE) & FIELD_MASK);
        r = (mag_b - r) & FIELD_MASK;
      end else begin
        q = twos_neg(q);
      end
    end
    res.quotient  = q;
    res.remainder = r;
    return res;
  endfunction

  // Draws an operand that mixes full-width values with short ones, so that the
  // division starts from many different leading-zero positions, plus negatives
  // of short values, powers of two and the boundary values.
  function automatic logic [DATA_W-1:0] shaped_operand();
    logic [DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      4, 5, 6: v = v >> $urandom_range(0, WIDTH - 1);
      7:       v = twos_neg(v >> $urandom_range(1, WIDTH - 1));
      8: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = ONE;
          2:       v = FIELD_MASK;
          3:       v = MOST_NEG;
          4:       v = MOST_POS;
          default: v = ONE << 1;
        endcase
      end
      9:       v = ONE << $urandom_range(0, WIDTH - 1);
      default: ;
    endcase
    return v & FIELD_MASK;
  endfunction

  // Offers one operand word, holding it until the divider takes it, and records
  // the predicted result once the handshake has happened.
  task automatic send_operands(input div_mode_t mode,
                               input logic [DATA_W-1:0] dividend,
                               input logic [DATA_W-1:0] divisor);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(divide_words(mode, dividend, divisor));
  endtask

  // Boundary values, both modes, each sign combination and both divide-by-zero cases.
  task automatic test_directed_corners();
    send_operands(OP_UNSIGNED, '0, ONE);
    send_operands(OP_UNSIGNED, FIELD_MASK, ONE);
    send_operands(OP_UNSIGNED, FIELD_MASK, FIELD_MASK);
    send_operands(OP_UNSIGNED, '0, FIELD_MASK);
    send_operands(OP_UNSIGNED, ONE, FIELD_MASK);
    send_operands(OP_UNSIGNED, FIELD_MASK, '0);
    send_operands(OP_UNSIGNED, DATA_W'(100), DATA_W'(7));
    send_operands(OP_UNSIGNED, FIELD_MASK, DATA_W'(2));
    send_operands(OP_UNSIGNED, MOST_NEG, DATA_W'(3));
    // Most negative over minus one wraps back to the most negative value.
    send_operands(OP_SIGNED, MOST_NEG, FIELD_MASK);
    send_operands(OP_SIGNED, MOST_NEG, ONE);
    send_operands(OP_SIGNED, FIELD_MASK, FIELD_MASK);
    send_operands(OP_SIGNED, MOST_NEG, MOST_NEG);
    // Negative dividend alone, with and without a remainder left over.
    send_operands(OP_SIGNED, twos_neg(DATA_W'(7)), DATA_W'(2));
    send_operands(OP_SIGNED, twos_neg(DATA_W'(8)), DATA_W'(2));
    send_operands(OP_SIGNED, DATA_W'(7), twos_neg(DATA_W'(2)));
    send_operands(OP_SIGNED, twos_neg(DATA_W'(7)), twos_neg(DATA_W'(2)));
    send_operands(OP_SIGNED, DATA_W'(7), DATA_W'(2));
    send_operands(OP_SIGNED, FIELD_MASK, MOST_NEG);
    send_operands(OP_SIGNED, twos_neg(DATA_W'(5)), '0);
    send_operands(OP_SIGNED, MOST_POS, FIELD_MASK);
    send_operands(OP_SIGNED, MOST_NEG, MOST_POS);
    send_operands(OP_SIGNED, '0, twos_neg(DATA_W'(3)));
  endtask

  // Random operand words in both modes with sender gaps and receiver stalls.
  task automatic test_random_operands(input int unsigned count);
    repeat (count) begin
      send_operands(div_mode_t'($urandom_range(0, 1)), shaped_operand(), shaped_operand());
    end
  endtask

  // Closing stretch with both sides always ready, so words run back to back.
  task automatic test_back_to_back(input int unsigned count);
    gaps_enabled   = 1'b0;
    stalls_enabled = 1'b0;
    test_random_operands(count);
  endtask

  // Receiver side: bursts of stall cycles at random, ready otherwise.
  initial begin
    forever begin
      @(posedge clk);
      if (stalls_enabled && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word.quotient    = out_tdata[DATA_W-1:0];
      got_word.remainder   = out_tdata[2*DATA_W-1:DATA_W];
      got_word.div_by_zero = out_tuser[0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got q=%h r=%h dz=%b",
                 $time, got_word.quotient, got_word.remainder, got_word.div_by_zero);
        mismatch_count++;
      end else begin
        want_word = pending_results.pop_front();
        if (got_word.quotient !== want_word.quotient) begin
          $display("%0t: quotient expected %h got %h",
                   $time, want_word.quotient, got_word.quotient);
          mismatch_count++;
        end
        if (got_word.remainder !== want_word.remainder) begin
          $display("%0t: remainder expected %h got %h",
                   $time, want_word.remainder, got_word.remainder);
          mismatch_count++;
        end
        if (got_word.div_by_zero !== want_word.div_by_zero) begin
          $display("%0t: divide_by_zero expected %b got %b",
                   $time, want_word.div_by_zero, got_word.div_by_zero);
          mismatch_count++;
        end
      end
    end
  end

  // Safety net far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_random_operands(900);
    test_back_to_back(150);
    in_tvalid <= 1'b0;
    // Drain the outstanding results, then leave room for any stray word.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (WIDTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rid_pkg.sv
rtl/core/rid_cell.sv
rtl/core/restoring_integer_divider.sv
rtl/core/rid_checker.sv
dv/tb_restoring_integer_divider.sv
